// File: hdl/threshold_zero_suppression_assert.svh
// Assertion macros for the zero suppression block
`ifndef THRESHOLD_ZERO_SUPPRESSION_ASSERT_SVH
`define THRESHOLD_ZERO_SUPPRESSION_ASSERT_SVH
// implication checked every clock outside reset
`define TZS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/tzs_pkg.sv
`timescale 1ns / 1ps
package tzs_pkg;

  localparam int unsigned CntW = 25;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [2:0] {
    PT_S8  = 3'd0,
    PT_U8  = 3'd1,
    PT_S16 = 3'd2,
    PT_U16 = 3'd3,
    PT_S32 = 3'd4,
    PT_U32 = 3'd5,
    PT_F32 = 3'd6,
    PT_F64 = 3'd7
  } pix_type_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_PIXEL_TYPE = 2'd1,
    REG_MAX_WORDS  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] pixel_bits;
    logic        frame_end;
  } in_beat_t;

  typedef struct packed {
    logic            kind;
    logic [23:0]     pixel_index;
    logic [31:0]     pixel_value;
    logic [CntW-1:0] kept_count;
    logic [CntW-1:0] total_hits;
    logic            overflowed;
    logic            is_last;
  } out_beat_t;

  // decoded pixel from the front end
  typedef struct packed {
    logic        over;
    logic [31:0] value;
  } dec_t;

  // double float -> truncated integer wrapped to 32 bits, plus exact compare
  // against a 32-bit signed threshold; value forced to 0 unless over. f64 bits given.
  function automatic dec_t f64_decode(logic [63:0] b, logic signed [31:0] thr);
    dec_t        r;
    logic        sgn;
    logic [10:0] ex;
    logic [52:0] mant;
    logic [84:0] sh;
    logic [31:0] ip;
    logic        frac;
    logic        big;
    logic        isnan;
    logic        isinf;
    logic [31:0] mag;
    logic signed [33:0] sv;
    int          e;
    sgn   = b[63];
    ex    = b[62:52];
    mant  = {(ex != 11'd0), b[51:0]};
    isnan = (ex == 11'h7FF) && (b[51:0] != '0);
    isinf = (ex == 11'h7FF) && (b[51:0] == '0);
    e     = int'(ex) - 1075;
    // integer part low 32 bits and whether magnitude >= 2^32
    ip = '0;
    frac = 1'b0;
    big = 1'b0;
    sh = '0;
    if (e >= 32) begin
      ip = '0;
      big = 1'b1;
    end else if (e >= 0) begin
      sh = {32'd0, mant} << e;
      ip = sh[31:0];
      big = (sh[84:32] != '0);
    end else if (e > -54) begin
      sh = {mant, 32'd0} >> (-e);
      ip = sh[63:32];
      big = (sh[84:64] != '0);
      // mantissa bits below the binary point
      frac = ((mant << (53 + e)) != '0);
    end else begin
      frac = (mant != '0);
    end
    if (isinf) ip = '0;
    mag = ip;
    r.value = sgn ? (32'd0 - mag) : mag;
    // exact compare; a fraction only lifts a positive value past an equal threshold
    if (isnan) begin
      r.over = 1'b0;
    end else if (isinf) begin
      r.over = !sgn;
    end else if (big) begin
      r.over = !sgn;
    end else begin
      sv = sgn ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      if (sgn)
        r.over = (sv > 34'(thr));
      else
        r.over = (sv > 34'(thr)) || ((sv == 34'(thr)) && frac);
    end
    if (!r.over) r.value = '0;
    return r;
  endfunction

  function automatic logic [63:0] f32_to_f64(logic [31:0] w);
    logic [63:0] d;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [4:0]  lz;
    logic [22:0] mn;
    ex = w[30:23];
    m  = w[22:0];
    d  = '0;
    d[63] = w[31];
    lz = '0;
    mn = '0;
    if (ex == 8'hFF) begin
      d[62:52] = 11'h7FF;
      d[51:29] = m;
    end else if (ex != 8'd0) begin
      d[62:52] = 11'(ex) + 11'd896;
      d[51:29] = m;
    end else if (m != '0) begin
      for (int i = 0; i < 23; i++) begin
        if (m[i]) lz = 5'(22 - i);
      end
      mn = m << (lz + 5'd1);
      d[62:52] = 11'd896 - 11'(lz);
      d[51:29] = mn;
    end
    return d;
  endfunction

endpackage

// File: hdl/tzs_decode.sv
`timescale 1ns / 1ps
// Pixel decode and threshold compare, purely combinational.
module tzs_decode (
  input  logic [63:0]        pixel_bits_i,
  input  logic [2:0]         pixel_type_i,
  input  logic signed [31:0] threshold_i,
  output tzs_pkg::dec_t      dec_o
);

  logic signed [32:0] iv;
  tzs_pkg::dec_t      fdec;

  // integer sign or zero extension
  always_comb begin
    case (tzs_pkg::pix_type_e'(pixel_type_i))
      tzs_pkg::PT_S8:  iv = 33'($signed(pixel_bits_i[7:0]));
      tzs_pkg::PT_U8:  iv = $signed({25'd0, pixel_bits_i[7:0]});
      tzs_pkg::PT_S16: iv = 33'($signed(pixel_bits_i[15:0]));
      tzs_pkg::PT_U16: iv = $signed({17'd0, pixel_bits_i[15:0]});
      tzs_pkg::PT_S32: iv = 33'($signed(pixel_bits_i[31:0]));
      default:         iv = $signed({1'b0, pixel_bits_i[31:0]});
    endcase
  end

  assign fdec = tzs_pkg::f64_decode(
      (pixel_type_i == tzs_pkg::PT_F32) ? tzs_pkg::f32_to_f64(pixel_bits_i[31:0])
                                        : pixel_bits_i, threshold_i);

  always_comb begin
    if (pixel_type_i == tzs_pkg::PT_F32 || pixel_type_i == tzs_pkg::PT_F64) begin
      dec_o = fdec;
    end else begin
      dec_o.over  = iv > 33'(threshold_i);
      dec_o.value = iv[31:0];
    end
  end

endmodule

// File: hdl/threshold_zero_suppression.sv
`timescale 1ns / 1ps
// A pixel beat accepted into the input register is decoded combinationally and its results
// are written into the output queue, whose head drives the output port directly.
// Throughput: one pixel per cycle when not stalled; a frame-end pixel that is also a kept
// hit yields two result beats, and the input stalls while queued results plus those of the
// pixel in decode exceed two (four-entry queue). Reset (rst_ni low, asynchronous): counters
// clear, threshold 0, pixel type u16, max_words 0; queue empties.
module threshold_zero_suppression #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tzs_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tzs_pkg::out_beat_t  out_data_o
);

  localparam int unsigned CW = tzs_pkg::CntW;

  logic signed [31:0] thr_q;
  logic [2:0]         type_q;
  logic [25:0]        words_q;

  logic                  v_q;
  tzs_pkg::in_beat_t     px_q;
  logic [INDEX_BITS-1:0] pix_q;
  logic [CW-1:0]         kept_q, hits_q;
  tzs_pkg::dec_t         dec;
  logic [CW-1:0]         cap;
  logic                  keep;
  logic [CW-1:0]         hits_n, kept_n;

  tzs_pkg::out_beat_t fifo_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic [1:0] npush;
  logic       pop;
  tzs_pkg::out_beat_t hit_b, sum_b;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      type_q  <= tzs_pkg::PT_U16;
      words_q <= '0;
    end else if (cfg_we_i) begin
      case (tzs_pkg::reg_idx_e'(cfg_idx_i))
        tzs_pkg::REG_THRESHOLD:  thr_q   <= cfg_data_i;
        tzs_pkg::REG_PIXEL_TYPE: type_q  <= cfg_data_i[2:0];
        tzs_pkg::REG_MAX_WORDS:  words_q <= cfg_data_i[25:0];
        default: ;
      endcase
    end
  end

  // accept only with room for two more results beyond the pixel in decode
  assign in_stall_o = (cnt_q + 3'(npush)) > 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= in_valid_i && !in_stall_o;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) px_q <= in_data_i;
  end

  tzs_decode u_dec (
    .pixel_bits_i (px_q.pixel_bits),
    .pixel_type_i (type_q),
    .threshold_i  (thr_q),
    .dec_o        (dec)
  );

  assign cap    = CW'(words_q[25:1]);
  assign keep   = dec.over && (kept_q < cap);
  assign hits_n = (dec.over && hits_q != tzs_pkg::CntMax) ? hits_q + 1'b1 : hits_q;
  assign kept_n = keep ? kept_q + 1'b1 : kept_q;

  always_comb begin
    hit_b = '0;
    hit_b.pixel_index = 24'(pix_q);
    hit_b.pixel_value = dec.value;
    sum_b = '0;
    sum_b.kind       = 1'b1;
    sum_b.kept_count = kept_n;
    sum_b.total_hits = hits_n;
    sum_b.overflowed = hits_n > cap;
    sum_b.is_last    = 1'b1;
  end

  // frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= '0;
      kept_q <= '0;
      hits_q <= '0;
    end else if (v_q) begin
      if (px_q.frame_end) begin
        pix_q  <= '0;
        kept_q <= '0;
        hits_q <= '0;
      end else begin
        pix_q  <= pix_q + 1'b1;
        kept_q <= kept_n;
        hits_q <= hits_n;
      end
    end
  end

  // output queue
  assign pop   = (cnt_q != 3'd0) && !out_stall_i;
  assign npush = v_q ? (2'(keep) + 2'(px_q.frame_end)) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (v_q) begin
      if (keep) begin
        fifo_q[wr_q] <= hit_b;
        if (px_q.frame_end) fifo_q[wr_q + 2'd1] <= sum_b;
      end else if (px_q.frame_end) begin
        fifo_q[wr_q] <= sum_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + npush;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(npush) - 3'(pop);
    end
  end

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = fifo_q[rd_q];

endmodule

// File: hdl/tzs_checker.sv
`timescale 1ns / 1ps
`include "threshold_zero_suppression_assert.svh"
// Port-level checks for the zero suppression block.
module tzs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tzs_pkg::out_beat_t out_data_o
);
  `TZS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `TZS_ASSERT_IMP(a_sum_last, clk_i, rst_ni, out_valid_o, out_data_o.kind == out_data_o.is_last)
  `TZS_ASSERT_IMP(a_hit_clean, clk_i, rst_ni, out_valid_o && !out_data_o.kind, out_data_o.kept_count == '0 && !out_data_o.overflowed)
  `TZS_ASSERT_IMP(a_sum_clean, clk_i, rst_ni, out_valid_o && out_data_o.kind, out_data_o.pixel_value == '0 && out_data_o.kept_count <= out_data_o.total_hits)
endmodule

bind threshold_zero_suppression tzs_checker u_tzs_checker (.*);
